// ===== design/umps_pkg.sv =====
// umps_pkg: shared types and constants of the masked pattern search core
// depends on nothing; imported by umps_out_if, umps_match and the top level
package umps_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int OFFSET_BITS       = 32;
	localparam int LEN_W             = 5;
	localparam int IDX_W             = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam int REG_W             = 64;
	localparam int REG_BYTES         = REG_W / 8;
	localparam int ADDR_W            = 6;
	localparam int RESULT_OFFSET_W   = 32;

	localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

	localparam logic [7:0] MASK_CMP = 8'hFF;
	localparam logic [7:0] MASK_ANY = 8'h00;

	// register indexes (byte address is 8 times the index)
	localparam logic [2:0] REG_PATTERN_LOW  = 3'd0;
	localparam logic [2:0] REG_PATTERN_HIGH = 3'd1;
	localparam logic [2:0] REG_MASK_LOW     = 3'd2;
	localparam logic [2:0] REG_MASK_HIGH    = 3'd3;
	localparam logic [2:0] REG_PATTERN_LEN  = 3'd4;

	typedef enum logic [1:0] {
		ST_SUCCESS   = 2'd0,
		ST_INVALID   = 2'd1,
		ST_COLLISION = 2'd2,
		ST_NOT_FOUND = 2'd3
	} scan_status_t;

	typedef logic [MAX_PATTERN_BYTES-1:0][7:0] window_t;

	typedef struct packed {
		window_t           pattern;
		window_t           mask;
		logic [LEN_W-1:0]  length;
	} match_cfg_t;

	typedef struct packed {
		logic hit;
		logic len_ok;
	} match_res_t;

endpackage

// ===== design/umps_if.sv =====
// umps_if: valid/ready channels of the masked pattern search core
// depends on umps_pkg
interface umps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] image_byte;
	logic       last_byte;

	modport source (output valid, output image_byte, output last_byte, input ready);
	modport sink   (input valid, input image_byte, input last_byte, output ready);
endinterface

interface umps_out_if;
	import umps_pkg::*;
	logic                         valid;
	logic                         ready;
	scan_status_t                 scan_status;
	logic [RESULT_OFFSET_W-1:0]   match_offset;

	modport source (output valid, output scan_status, output match_offset, input ready);
	modport sink   (input valid, input scan_status, input match_offset, output ready);
endinterface

// ===== design/umps_match.sv =====
// umps_match: masked compare of the newest pattern bytes of the window
// depends on umps_pkg
module umps_match (
	input  umps_pkg::window_t    window,
	input  umps_pkg::match_cfg_t cfg,
	output umps_pkg::match_res_t res
);
	import umps_pkg::*;

	always_comb begin
		logic [LEN_W:0] pos;
		logic [7:0]     m;
		logic [7:0]     p;
		logic [7:0]     w;
		logic           ok;
		res.len_ok = (cfg.length != '0) &&
			({1'b0, cfg.length} <= (LEN_W+1)'(MAX_PATTERN_BYTES));
		ok = 1'b1;
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			// pattern byte i lines up with window byte MAX - length + i
			pos = (LEN_W+1)'(MAX_PATTERN_BYTES + i) - {1'b0, cfg.length};
			m   = cfg.mask[i];
			p   = cfg.pattern[i];
			w   = window[pos[IDX_W-1:0]];
			if ((LEN_W+1)'(i) < {1'b0, cfg.length}) begin
				if (m != MASK_CMP && m != MASK_ANY) begin
					ok = 1'b0;
				end else if (m == MASK_CMP && w != p) begin
					ok = 1'b0;
				end
			end
		end
		res.hit = ok && res.len_ok;
	end

endmodule

// ===== design/unique_masked_pattern_search_core.sv =====
// unique_masked_pattern_search_core: masked byte signature scan with uniqueness check
// depends on umps_pkg, umps_if (umps_in_if, umps_out_if) and umps_match
// a final byte's result passes the window register, then the result register
// throughput: one byte per cycle; only a final byte can stall, when the result register is full
// the single-bit match/collision update between consecutive bytes bounds the rate
// reset: arst_n clears config registers, window, counters and both handshake stages at once
module unique_masked_pattern_search_core (
	input  logic                          clk,
	input  logic                          arst_n,
	umps_in_if.sink                       image,
	umps_out_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [umps_pkg::ADDR_W-1:0]   paddr,
	input  logic [umps_pkg::REG_W-1:0]    pwdata,
	output logic [umps_pkg::REG_W-1:0]    prdata,
	output logic                          pready
);
	import umps_pkg::*;

	// configuration registers
	logic [REG_W-1:0] pattern_low_q;
	logic [REG_W-1:0] pattern_high_q;
	logic [REG_W-1:0] mask_low_q;
	logic [REG_W-1:0] mask_high_q;
	logic [LEN_W-1:0] pattern_len_q;

	// scan stage: window and byte count belong to the item held in s1
	window_t                 window_q;
	logic [OFFSET_BITS-1:0]  count_q;
	logic                    valid_s1;
	logic                    last_s1;

	// match history of the current image
	logic                    match_q;
	logic                    collision_q;
	logic [OFFSET_BITS-1:0]  found_q;

	// result register
	logic                        out_valid_q;
	scan_status_t                status_q;
	logic [RESULT_OFFSET_W-1:0]  offset_q;

	match_cfg_t              cfg;
	match_res_t              mres;
	logic [2:0]              reg_idx;
	logic                    cfg_wr;
	logic                    in_xfer;
	logic                    fire;
	logic                    step_hit;
	logic                    enough;
	logic                    match_now;
	logic                    collision_now;
	logic [OFFSET_BITS-1:0]  offset_now;
	logic [OFFSET_BITS-1:0]  len_ext;
	scan_status_t            status_now;

	// ---------------- APB configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			mask_low_q     <= '0;
			mask_high_q    <= '0;
			pattern_len_q  <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PATTERN_LOW:  pattern_low_q  <= pwdata;
				REG_PATTERN_HIGH: pattern_high_q <= pwdata;
				REG_MASK_LOW:     mask_low_q     <= pwdata;
				REG_MASK_HIGH:    mask_high_q    <= pwdata;
				REG_PATTERN_LEN:  pattern_len_q  <= pwdata[LEN_W-1:0];
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PATTERN_LOW:  prdata = pattern_low_q;
			REG_PATTERN_HIGH: prdata = pattern_high_q;
			REG_MASK_LOW:     prdata = mask_low_q;
			REG_MASK_HIGH:    prdata = mask_high_q;
			REG_PATTERN_LEN:  prdata = REG_W'(pattern_len_q);
			default:          prdata = '0;
		endcase
	end

	// byte 0 of the pattern sits in bits 7..0 of the low register
	assign cfg.pattern = window_t'({pattern_high_q, pattern_low_q});
	assign cfg.mask    = window_t'({mask_high_q, mask_low_q});
	assign cfg.length  = pattern_len_q;

	// ---------------- handshake ----------------
	// a non-final byte always moves on; a final byte needs a free result register
	assign fire     = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign image.ready = !valid_s1 || fire;
	assign in_xfer  = image.valid && image.ready;

	// ---------------- window and count ----------------
	// when the previous byte closed an image, the new byte starts a fresh window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			count_q  <= '0;
			last_s1  <= 1'b0;
		end else if (in_xfer) begin
			if (last_s1) begin
				window_q <= '0;
				window_q[MAX_PATTERN_BYTES-1] <= image.image_byte;
				count_q  <= OFFSET_BITS'(1);
			end else begin
				for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
					window_q[i] <= window_q[i+1];
				end
				window_q[MAX_PATTERN_BYTES-1] <= image.image_byte;
				// count saturates at all ones
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + OFFSET_BITS'(1);
				end
			end
			last_s1 <= image.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (image.ready) begin
			valid_s1 <= image.valid;
		end
	end

	// ---------------- compare ----------------
	umps_match u_match (
		.window (window_q),
		.cfg    (cfg),
		.res    (mres)
	);

	assign len_ext       = OFFSET_BITS'(pattern_len_q);
	assign enough        = count_q >= len_ext;
	assign step_hit      = mres.hit && enough;
	assign match_now     = match_q || step_hit;
	assign collision_now = collision_q || (step_hit && match_q);
	// the first matching offset is kept; later hits only flag a collision
	assign offset_now    = match_q ? found_q : (count_q - len_ext);

	always_comb begin
		if (!mres.len_ok || !enough) begin
			status_now = ST_INVALID;
		end else if (collision_now) begin
			status_now = ST_COLLISION;
		end else if (match_now) begin
			status_now = ST_SUCCESS;
		end else begin
			status_now = ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= 1'b0;
			collision_q <= 1'b0;
			found_q     <= '0;
		end else if (fire) begin
			if (last_s1) begin
				// image done: history goes back to its cleared state
				match_q     <= 1'b0;
				collision_q <= 1'b0;
				found_q     <= '0;
			end else begin
				match_q     <= match_now;
				collision_q <= collision_now;
				found_q     <= offset_now;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			status_q <= status_now;
			offset_q <= (status_now == ST_SUCCESS) ?
				offset_now[RESULT_OFFSET_W-1:0] : '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.scan_status  = status_q;
	assign result.match_offset = offset_q;

`ifndef NO_ASSERTIONS
	// a collision can only follow a recorded match
	a_collision_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		collision_q |-> match_q)
		else $error("collision flagged without a match");

	// an offset is reported only for a unique match
	a_offset_only_on_success: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_SUCCESS) |-> (offset_q == '0))
		else $error("nonzero offset on a non-success result");

	// the byte after a final byte restarts the count
	a_count_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && last_s1) |=> (count_q == OFFSET_BITS'(1)))
		else $error("byte count did not restart after final byte");

	// the input stalls only for a final byte facing a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!image.ready |-> (valid_s1 && last_s1 && out_valid_q && !result.ready))
		else $error("input stalled without a pending final byte");
`endif

endmodule
